[rtl/core/x86_16_register_alu_and_branch_core_macros.svh]
// assertion macros for the core's checking code
`ifndef X86_16_REGISTER_ALU_AND_BRANCH_CORE_MACROS_SVH
`define X86_16_REGISTER_ALU_AND_BRANCH_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define XRAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define XRAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/xrab_pkg.sv]
// shared types, constants and helpers of the register alu and branch core
package xrab_pkg;

  localparam int WORD_W   = 16;
  localparam int FLAG_W   = 12;
  localparam int RF_DEPTH = 12;
  localparam int RF_IDX_W = 4;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [RF_IDX_W-1:0] SEG_BASE = 4'd8;
  localparam logic [RF_IDX_W-1:0] CX_IDX   = 4'd1;

  localparam int FLAG_C = 0;
  localparam int FLAG_P = 2;
  localparam int FLAG_A = 4;
  localparam int FLAG_Z = 6;
  localparam int FLAG_S = 7;
  localparam int FLAG_O = 11;

  typedef enum logic [3:0] {
    CMD_MOV    = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_CMP    = 4'd3,
    CMD_JNZ    = 4'd4,
    CMD_JE     = 4'd5,
    CMD_JP     = 4'd6,
    CMD_JB     = 4'd7,
    CMD_LOOPNZ = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    SEG_NONE = 2'd0,
    SEG_TO   = 2'd1,
    SEG_FROM = 2'd2
  } seg_sel_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_MOV    = 2'd1,
    K_ARITH  = 2'd2,
    K_BRANCH = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    C_JNZ    = 3'd0,
    C_JE     = 3'd1,
    C_JP     = 3'd2,
    C_JB     = 3'd3,
    C_LOOPNZ = 3'd4
  } cond_t;

  // classified operation handed from the front to the back
  typedef struct packed {
    kind_t               kind;
    logic                sub;
    logic                wr;
    cond_t               cond;
    logic                wide;
    logic                use_imm;
    logic [WORD_W-1:0]   imm;
    logic [RF_IDX_W-1:0] dst_idx;
    logic [RF_IDX_W-1:0] src_idx;
    logic                dst_hi;
    logic                src_hi;
  } op_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } b_stat_t;

  function automatic logic parity_even(input logic [7:0] v);
    parity_even = ~^v;
  endfunction

endpackage

[rtl/core/xrab_front.sv]
// front end: accepts items and classifies them into operations
module xrab_front
  import xrab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[3:0]
  input  logic [3:0]  s_tuser,
  // dest_code[2:0] src_code[5:3] segment_select[7:6] wide[8] use_immediate[9]
  // immediate_value[25:10] memory_operand[26], zero above
  input  logic [31:0] s_tdata,
  output logic        push_valid,
  output op_t         push_op,
  input  logic        push_ready
);

  logic        fv;
  op_t         fop;
  op_t         op_next;
  logic [2:0]  dcode;
  logic [2:0]  scode;
  logic [1:0]  segsel;
  logic        wide;
  logic        mem;

  assign dcode  = s_tdata[2:0];
  assign scode  = s_tdata[5:3];
  assign segsel = s_tdata[7:6];
  assign wide   = s_tdata[8];
  assign mem    = s_tdata[26];

  always_comb begin
    op_next         = '0;
    op_next.kind    = K_NONE;
    op_next.cond    = C_JNZ;
    op_next.wide    = wide;
    op_next.use_imm = s_tdata[9];
    op_next.imm     = s_tdata[25:10];
    // byte codes 4..7 name the high half of registers 0..3
    op_next.dst_idx = wide ? {1'b0, dcode} : {2'b00, dcode[1:0]};
    op_next.src_idx = wide ? {1'b0, scode} : {2'b00, scode[1:0]};
    op_next.dst_hi  = !wide && dcode[2];
    op_next.src_hi  = !wide && scode[2];
    if (!mem) begin
      unique case (cmd_t'(s_tuser))
        CMD_MOV: begin
          op_next.kind = K_MOV;
          op_next.wr   = 1'b1;
          if (seg_sel_t'(segsel) == SEG_TO) begin
            op_next.wide    = 1'b1;
            op_next.dst_idx = SEG_BASE | {2'b00, dcode[1:0]};
            op_next.src_idx = {1'b0, scode};
            op_next.dst_hi  = 1'b0;
            op_next.src_hi  = 1'b0;
          end else if (seg_sel_t'(segsel) == SEG_FROM) begin
            op_next.wide    = 1'b1;
            op_next.use_imm = 1'b0;
            op_next.dst_idx = {1'b0, dcode};
            op_next.src_idx = SEG_BASE | {2'b00, scode[1:0]};
            op_next.dst_hi  = 1'b0;
            op_next.src_hi  = 1'b0;
          end
        end
        CMD_ADD: begin
          op_next.kind = K_ARITH;
          op_next.wr   = 1'b1;
        end
        CMD_SUB: begin
          op_next.kind = K_ARITH;
          op_next.sub  = 1'b1;
          op_next.wr   = 1'b1;
        end
        CMD_CMP: begin
          op_next.kind = K_ARITH;
          op_next.sub  = 1'b1;
        end
        CMD_JNZ: begin
          op_next.kind = K_BRANCH;
          op_next.cond = C_JNZ;
        end
        CMD_JE: begin
          op_next.kind = K_BRANCH;
          op_next.cond = C_JE;
        end
        CMD_JP: begin
          op_next.kind = K_BRANCH;
          op_next.cond = C_JP;
        end
        CMD_JB: begin
          op_next.kind = K_BRANCH;
          op_next.cond = C_JB;
        end
        CMD_LOOPNZ: begin
          // the decremented count goes back into cx
          op_next.kind    = K_BRANCH;
          op_next.cond    = C_LOOPNZ;
          op_next.wr      = 1'b1;
          op_next.wide    = 1'b1;
          op_next.dst_idx = CX_IDX;
          op_next.dst_hi  = 1'b0;
        end
        default: op_next.kind = K_NONE;
      endcase
    end
  end

  assign s_tready   = !fv || push_ready;
  assign push_valid = fv;
  assign push_op    = fop;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      fop <= op_next;
    end
  end

endmodule

[rtl/core/xrab_queue.sv]
// short operation queue between front and back
module xrab_queue
  import xrab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_op    = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= in_op;
    end
  end

endmodule

[rtl/core/xrab_back.sv]
// back end: register read stage, execute stage and output register
module xrab_back
  import xrab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  op_t         q_op,
  output logic        m_tvalid,
  input  logic        m_tready,
  // dest_value[15:0] flag_word[27:16] branch_taken[28] count_value[44:29], zero above
  output logic [47:0] m_tdata,
  output b_stat_t     stat
);

  // register file: written at one address, read at two with registered data
  logic [WORD_W-1:0]   rf [RF_DEPTH];
  logic [RF_DEPTH-1:0] rf_valid;
  logic [WORD_W-1:0]   cx;
  logic [FLAG_W-1:0]   flags;

  // last register write, for operands read before it landed
  logic                fwd_en;
  logic [RF_IDX_W-1:0] fwd_idx;
  logic [WORD_W-1:0]   fwd_data;

  logic                a_valid;
  op_t                 a_op;
  logic [WORD_W-1:0]   a_rd_dst;
  logic [WORD_W-1:0]   a_rd_src;
  logic [RF_IDX_W-1:0] rd_idx_dst;
  logic [RF_IDX_W-1:0] rd_idx_src;
  logic [WORD_W-1:0]   a_cor_dst;
  logic [WORD_W-1:0]   a_cor_src;

  logic                b_valid;
  op_t                 b_op;
  logic [WORD_W-1:0]   b_rd_dst;
  logic [WORD_W-1:0]   b_rd_src;

  logic                out_free;
  logic                b_fire;
  logic                b_load;
  logic                a_load;

  logic [WORD_W-1:0]   dst_word;
  logic [WORD_W-1:0]   src_word;
  logic [WORD_W-1:0]   opa;
  logic [WORD_W-1:0]   opb;
  logic [WORD_W:0]     sum;
  logic [WORD_W-1:0]   res;
  logic [WORD_W-1:0]   ovf_vec;
  logic [WORD_W-1:0]   new_word;
  logic [FLAG_W-1:0]   new_flags;
  logic [WORD_W-1:0]   cx_dec;
  logic                wr_en;
  logic                taken;
  logic [WORD_W-1:0]   dest_out;
  logic [WORD_W-1:0]   count_out;
  logic [FLAG_W-1:0]   flags_out;

  assign out_free = !m_tvalid || m_tready;
  assign b_fire   = b_valid && out_free;
  assign b_load   = a_valid && (!b_valid || b_fire);
  assign a_load   = q_valid && (!a_valid || b_load);
  assign q_pop    = a_load;

  assign stat.a_valid = a_valid;
  assign stat.b_valid = b_valid;

  // read stage keeps rereading for the item it holds
  assign rd_idx_dst = a_load ? q_op.dst_idx : a_op.dst_idx;
  assign rd_idx_src = a_load ? q_op.src_idx : a_op.src_idx;

  assign a_cor_dst = (fwd_en && fwd_idx == a_op.dst_idx) ? fwd_data : a_rd_dst;
  assign a_cor_src = (fwd_en && fwd_idx == a_op.src_idx) ? fwd_data : a_rd_src;
  assign dst_word  = (fwd_en && fwd_idx == b_op.dst_idx) ? fwd_data : b_rd_dst;
  assign src_word  = (fwd_en && fwd_idx == b_op.src_idx) ? fwd_data : b_rd_src;

  always_comb begin
    opa = b_op.wide ? dst_word
                    : {8'h00, (b_op.dst_hi ? dst_word[15:8] : dst_word[7:0])};
    if (b_op.use_imm) begin
      opb = b_op.wide ? b_op.imm : {8'h00, b_op.imm[7:0]};
    end else begin
      opb = b_op.wide ? src_word
                      : {8'h00, (b_op.src_hi ? src_word[15:8] : src_word[7:0])};
    end
    sum = b_op.sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
    if (b_op.kind == K_MOV) begin
      res = opb;
    end else begin
      res = b_op.wide ? sum[15:0] : {8'h00, sum[7:0]};
    end
    ovf_vec = b_op.sub ? ((opa ^ opb) & (opa ^ res)) : (~(opa ^ opb) & (opa ^ res));

    new_flags         = '0;
    // byte add carries out of bit 7; a borrow always shows in the top bit
    new_flags[FLAG_C] = (!b_op.wide && !b_op.sub) ? sum[8] : sum[16];
    new_flags[FLAG_P] = parity_even(res[7:0]);
    new_flags[FLAG_A] = opa[4] ^ opb[4] ^ res[4];
    new_flags[FLAG_Z] = res == '0;
    new_flags[FLAG_S] = b_op.wide ? res[15] : res[7];
    new_flags[FLAG_O] = b_op.wide ? ovf_vec[15] : ovf_vec[7];

    cx_dec = cx - 1'b1;

    if (b_op.kind == K_BRANCH) begin
      new_word = cx_dec;
    end else if (b_op.wide) begin
      new_word = res;
    end else if (b_op.dst_hi) begin
      new_word = {res[7:0], dst_word[7:0]};
    end else begin
      new_word = {dst_word[15:8], res[7:0]};
    end

    wr_en = (b_op.kind == K_MOV || b_op.kind == K_ARITH ||
             (b_op.kind == K_BRANCH && b_op.cond == C_LOOPNZ)) && b_op.wr;

    taken = 1'b0;
    if (b_op.kind == K_BRANCH) begin
      unique case (b_op.cond)
        C_JNZ:    taken = !flags[FLAG_Z];
        C_JE:     taken = flags[FLAG_Z];
        C_JP:     taken = flags[FLAG_P];
        C_JB:     taken = flags[FLAG_C];
        C_LOOPNZ: taken = (cx_dec != '0) && !flags[FLAG_Z];
        default:  taken = 1'b0;
      endcase
    end

    if (b_op.kind == K_MOV || b_op.kind == K_ARITH) begin
      dest_out = wr_en ? new_word : dst_word;
    end else begin
      dest_out = '0;
    end

    if (b_op.kind == K_BRANCH && b_op.cond == C_LOOPNZ) begin
      count_out = cx_dec;
    end else if (wr_en && b_op.dst_idx == CX_IDX) begin
      count_out = new_word;
    end else begin
      count_out = cx;
    end

    flags_out = (b_op.kind == K_ARITH) ? new_flags : flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      rf_valid <= '0;
      fwd_en   <= 1'b0;
      cx       <= '0;
      flags    <= '0;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (b_fire) begin
        cx    <= count_out;
        flags <= flags_out;
        if (wr_en) begin
          rf_valid[b_op.dst_idx] <= 1'b1;
          fwd_en                 <= 1'b1;
        end
      end
    end

    a_rd_dst <= rf_valid[rd_idx_dst] ? rf[rd_idx_dst] : '0;
    a_rd_src <= rf_valid[rd_idx_src] ? rf[rd_idx_src] : '0;
    if (a_load) begin
      a_op <= q_op;
    end
    if (b_load) begin
      b_op     <= a_op;
      b_rd_dst <= a_cor_dst;
      b_rd_src <= a_cor_src;
    end
    if (b_fire && wr_en) begin
      rf[b_op.dst_idx] <= new_word;
      fwd_idx          <= b_op.dst_idx;
      fwd_data         <= new_word;
    end
    if (b_fire) begin
      m_tdata <= {3'b000, count_out, taken, flags_out, dest_out};
    end
  end

endmodule

[rtl/core/x86_16_register_alu_and_branch_core.sv]
// top level of the 8086 register alu and branch execute core
//
// Input channel s_*: one decoded instruction per item (mov, add, sub, cmp,
// jnz, je, jp, jb, loopnz). Output channel m_*: one result item for every
// input item, in order: destination register, flag word, branch decision
// and CX after the instruction.
// Path from acceptance to result: front register, queue, register read
// stage, execute stage and the output register.
// Throughput: one item per cycle while m_tready is high; the register file
// write, the flag update and the bypass load when the execute stage fires.
// The front classifies items into a 2-entry queue, so the front keeps
// taking items while the back waits on the output side.
// Reset clears all twelve registers and the flags to zero and empties the
// pipeline. When m_tready is low the output holds, the back stages stop,
// the queue fills and s_tready falls once the front register is also full.
module x86_16_register_alu_and_branch_core
  import xrab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[3:0]
  input  logic [3:0]  s_tuser,
  // dest_code[2:0] src_code[5:3] segment_select[7:6] wide[8] use_immediate[9]
  // immediate_value[25:10] memory_operand[26], zero above
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // dest_value[15:0] flag_word[27:16] branch_taken[28] count_value[44:29], zero above
  output logic [47:0] m_tdata
);

`include "x86_16_register_alu_and_branch_core_macros.svh"

  logic    f_valid;
  op_t     f_op;
  logic    q_in_ready;
  logic    q_valid;
  logic    q_pop;
  op_t     q_op;
  b_stat_t stat;

  xrab_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .push_valid (f_valid),
    .push_op    (f_op),
    .push_ready (q_in_ready)
  );

  xrab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_in_ready),
    .in_op     (f_op),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_op    (q_op)
  );

  xrab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .stat     (stat)
  );

  `XRAB_ASSERT_NEXT(a_front_holds, f_valid && !q_in_ready, f_valid, "front item lost while queue full")
  `XRAB_ASSERT_NEXT(a_exec_holds, m_tvalid && !m_tready && stat.b_valid, stat.b_valid, "execute stage lost an item while output stalled")
  `XRAB_ASSERT_IMPL(a_reset_empty, $past(rst), !m_tvalid && !stat.a_valid && !stat.b_valid, "pipeline not empty after reset")

endmodule
